### hdl/binary_max_heap_queue_defines.svh
// ----------------------------------------------------------------------------
// binary_max_heap_queue_defines
// Assertion macros shared by the heap queue checker.
// ----------------------------------------------------------------------------
`ifndef BINARY_MAX_HEAP_QUEUE_DEFINES_SVH
`define BINARY_MAX_HEAP_QUEUE_DEFINES_SVH

// same-cycle implication, disabled during reset
`define BMHQ_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled during reset
`define BMHQ_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### hdl/bmhq_pkg.sv
// ----------------------------------------------------------------------------
// bmhq_pkg
// Types, codes and constants shared by the heap queue controller, datapath,
// top level and checker.
// ----------------------------------------------------------------------------
`default_nettype none

package bmhq_pkg;

   // fixed port widths
   localparam int VALUE_W  = 32;
   localparam int STATUS_W = 2;
   localparam int TOTAL_W  = 11;

   // parameter defaults
   localparam int DEF_CAPACITY  = 1024;
   localparam int DEF_KEY_WIDTH = 32;

   typedef enum logic {
      OP_INSERT = 1'b0,
      OP_POP    = 1'b1
   } opcode_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_DONE  = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   // read address select
   typedef enum logic [2:0] {
      RA_ROOT,
      RA_LAST,
      RA_PARENT,
      RA_GRAND,
      RA_LEFT,
      RA_RIGHT,
      RA_BEST_LEFT
   } rd_addr_type;

   // write data select, always written at the hole
   typedef enum logic [1:0] {
      WD_KEY,
      WD_RD,
      WD_BEST
   } wr_data_type;

   typedef enum logic [2:0] {
      HO_KEEP,
      HO_COUNT,
      HO_ROOT,
      HO_PARENT,
      HO_LEFT,
      HO_BEST
   } hole_op_type;

   typedef enum logic [1:0] {
      CO_KEEP,
      CO_INC,
      CO_DEC
   } cnt_op_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_DISPATCH,
      S_UP_READ,
      S_UP_CMP,
      S_POP_ROOT,
      S_POP_LAST,
      S_DN_LEFT,
      S_DN_RIGHT,
      S_PLACE,
      S_RESPOND
   } state_type;

   // controller to datapath commands
   typedef struct packed {
      logic        load_req;
      logic        rd_en;
      rd_addr_type rd_addr;
      logic        wr_en;
      wr_data_type wr_data;
      hole_op_type hole_op;
      cnt_op_type  cnt_op;
      logic        load_key_rd;
      logic        load_popped;
      logic        load_left;
      logic        clr_popped;
      logic        set_status;
      status_type  status_code;
      logic        respond;
   } ctrl_cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic op_pop;
      logic count_full;
      logic count_zero;
      logic parent_zero;
      logic key_gt_rd;
      logic rd_gt_key;
      logic left_in;
      logic right_in;
      logic best_gt_key;
      logic best_left_in;
      logic out_busy;
   } dp_stat_type;

endpackage

`default_nettype wire

### hdl/binary_max_heap_queue.sv
// ----------------------------------------------------------------------------
// binary_max_heap_queue
// Max-priority queue on an array-based binary heap: insert sifts up,
// pop returns the root and sifts the last entry down.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake         | beat
//  req_     | in        | req_valid/stall   | opcode, value
//  rsp_     | out       | rsp_valid/stall   | popped_value, status, entry_total
//
//  One operation at a time; req_stall is high from the accept until the
//  result is loaded into the output register; idle then accepts again.
//  Insert climbs one level per parent compare; an empty heap takes the key
//  directly, a full one refuses it. Pop reads root and last entry, then
//  both children per level (left only for a lone left child); empty pops
//  just respond. Reset clears state, count and output valid only.
// ----------------------------------------------------------------------------
`default_nettype none

module binary_max_heap_queue #(
   parameter int CAPACITY  = bmhq_pkg::DEF_CAPACITY,
   parameter int KEY_WIDTH = bmhq_pkg::DEF_KEY_WIDTH
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_valid,
   output logic                                      req_stall,
   input  wire logic                                 req_opcode,
   input  wire logic signed [bmhq_pkg::VALUE_W-1:0]  req_value,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_stall,
   output logic signed [bmhq_pkg::VALUE_W-1:0]       rsp_popped_value,
   output logic [bmhq_pkg::STATUS_W-1:0]             rsp_status,
   output logic [bmhq_pkg::TOTAL_W-1:0]              rsp_entry_total
);
   import bmhq_pkg::*;

   ctrl_cmd_type cmd;
   dp_stat_type  stat;

   // sequencer
   bmhq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   // store and working registers
   bmhq_dpath #(
      .CAPACITY  (CAPACITY),
      .KEY_WIDTH (KEY_WIDTH)
   ) u_dpath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .stat             (stat),
      .req_opcode       (req_opcode),
      .req_value        (req_value),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_popped_value (rsp_popped_value),
      .rsp_status       (rsp_status),
      .rsp_entry_total  (rsp_entry_total)
   );

endmodule

`default_nettype wire

### hdl/bmhq_ctrl.sv
// ----------------------------------------------------------------------------
// bmhq_ctrl
// Sequencer for insert sift-up and pop sift-down; drives the datapath by
// commands and steers on its status flags.
// ----------------------------------------------------------------------------
`default_nettype none

module bmhq_ctrl (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_stall,
   input  wire bmhq_pkg::dp_stat_type   stat,
   output bmhq_pkg::ctrl_cmd_type       cmd
);
   import bmhq_pkg::*;

   state_type state_ff;
   state_type state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and commands
   always_comb begin
      cmd       = '0;
      state_in  = state_ff;
      req_stall = (state_ff != S_IDLE);
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load_req = 1'b1;
               state_in     = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            cmd.set_status  = 1'b1;
            cmd.clr_popped  = 1'b1;
            cmd.status_code = ST_DONE;
            if (!stat.op_pop) begin
               if (stat.count_full) begin
                  cmd.status_code = ST_FULL;
                  state_in        = S_RESPOND;
               end else begin
                  cmd.hole_op = HO_COUNT;
                  cmd.cnt_op  = CO_INC;
                  state_in    = stat.count_zero ? S_PLACE : S_UP_READ;
               end
            end else begin
               if (stat.count_zero) begin
                  cmd.status_code = ST_EMPTY;
                  state_in        = S_RESPOND;
               end else begin
                  cmd.hole_op = HO_ROOT;
                  cmd.cnt_op  = CO_DEC;
                  cmd.rd_en   = 1'b1;
                  cmd.rd_addr = RA_ROOT;
                  state_in    = S_POP_ROOT;
               end
            end
         end
         S_UP_READ: begin
            cmd.rd_en   = 1'b1;
            cmd.rd_addr = RA_PARENT;
            state_in    = S_UP_CMP;
         end
         S_UP_CMP: begin
            // parent moves down into the hole while the key is larger
            if (stat.key_gt_rd) begin
               cmd.wr_en   = 1'b1;
               cmd.wr_data = WD_RD;
               cmd.hole_op = HO_PARENT;
               if (stat.parent_zero) begin
                  state_in = S_PLACE;
               end else begin
                  cmd.rd_en   = 1'b1;
                  cmd.rd_addr = RA_GRAND;
                  state_in    = S_UP_CMP;
               end
            end else begin
               state_in = S_PLACE;
            end
         end
         S_POP_ROOT: begin
            cmd.load_popped = 1'b1;
            cmd.rd_en       = 1'b1;
            cmd.rd_addr     = RA_LAST;
            state_in        = S_POP_LAST;
         end
         S_POP_LAST: begin
            cmd.load_key_rd = 1'b1;
            if (stat.left_in) begin
               cmd.rd_en   = 1'b1;
               cmd.rd_addr = RA_LEFT;
               state_in    = S_DN_LEFT;
            end else begin
               state_in = S_PLACE;
            end
         end
         S_DN_LEFT: begin
            cmd.load_left = 1'b1;
            if (stat.right_in) begin
               cmd.rd_en   = 1'b1;
               cmd.rd_addr = RA_RIGHT;
               state_in    = S_DN_RIGHT;
            end else begin
               // lone left child is the last entry
               if (stat.rd_gt_key) begin
                  cmd.wr_en   = 1'b1;
                  cmd.wr_data = WD_RD;
                  cmd.hole_op = HO_LEFT;
               end
               state_in = S_PLACE;
            end
         end
         S_DN_RIGHT: begin
            if (stat.best_gt_key) begin
               cmd.wr_en   = 1'b1;
               cmd.wr_data = WD_BEST;
               cmd.hole_op = HO_BEST;
               if (stat.best_left_in) begin
                  cmd.rd_en   = 1'b1;
                  cmd.rd_addr = RA_BEST_LEFT;
                  state_in    = S_DN_LEFT;
               end else begin
                  state_in = S_PLACE;
               end
            end else begin
               state_in = S_PLACE;
            end
         end
         S_PLACE: begin
            cmd.wr_en   = 1'b1;
            cmd.wr_data = WD_KEY;
            state_in    = S_RESPOND;
         end
         S_RESPOND: begin
            if (!stat.out_busy) begin
               cmd.respond = 1'b1;
               state_in    = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

### hdl/bmhq_dpath.sv
// ----------------------------------------------------------------------------
// bmhq_dpath
// Heap store, entry count, hole pointer, moving key and result register.
// Sifting moves a hole instead of swapping; the key lands once at the end.
// ----------------------------------------------------------------------------
`default_nettype none

module bmhq_dpath #(
   parameter int CAPACITY  = bmhq_pkg::DEF_CAPACITY,
   parameter int KEY_WIDTH = bmhq_pkg::DEF_KEY_WIDTH
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire bmhq_pkg::ctrl_cmd_type               cmd,
   output bmhq_pkg::dp_stat_type                     stat,
   input  wire logic                                 req_opcode,
   input  wire logic signed [bmhq_pkg::VALUE_W-1:0]  req_value,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_stall,
   output logic signed [bmhq_pkg::VALUE_W-1:0]       rsp_popped_value,
   output logic [bmhq_pkg::STATUS_W-1:0]             rsp_status,
   output logic [bmhq_pkg::TOTAL_W-1:0]              rsp_entry_total
);
   import bmhq_pkg::*;

   localparam int IDX_W = $clog2(CAPACITY);
   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int EXT_W = IDX_W + 2;

   logic signed [KEY_WIDTH-1:0] heap_mem [CAPACITY];

   logic signed [KEY_WIDTH-1:0] key_ff;
   logic signed [KEY_WIDTH-1:0] rd_data_ff;
   logic signed [KEY_WIDTH-1:0] left_val_ff;
   logic signed [KEY_WIDTH-1:0] popped_ff;
   logic [IDX_W-1:0]            hole_ff;
   logic [IDX_W-1:0]            hole_in;
   logic [CNT_W-1:0]            count_ff;
   logic [CNT_W-1:0]            count_in;
   opcode_type                  op_ff;
   status_type                  res_status_ff;
   logic                        rsp_valid_ff;
   logic signed [VALUE_W-1:0]   rsp_popped_ff;
   logic [STATUS_W-1:0]         rsp_status_ff;
   logic [TOTAL_W-1:0]          rsp_total_ff;

   logic [IDX_W-1:0]            parent_idx;
   logic [IDX_W-1:0]            grand_idx;
   logic [EXT_W-1:0]            left_ext;
   logic [EXT_W-1:0]            right_ext;
   logic [EXT_W-1:0]            count_ext;
   logic [EXT_W-1:0]            best_left_ext;
   logic [IDX_W-1:0]            left_idx;
   logic [IDX_W-1:0]            right_idx;
   logic [IDX_W-1:0]            best_idx;
   logic                        right_wins;
   logic signed [KEY_WIDTH-1:0] best_val;
   logic [IDX_W-1:0]            rd_addr;
   logic signed [KEY_WIDTH-1:0] wr_data;

   // tree index arithmetic around the hole
   always_comb begin
      parent_idx    = (hole_ff - IDX_W'(1)) >> 1;
      grand_idx     = (parent_idx - IDX_W'(1)) >> 1;
      left_ext      = {1'b0, hole_ff, 1'b1};
      right_ext     = left_ext + EXT_W'(1);
      count_ext     = EXT_W'(count_ff);
      left_idx      = left_ext[IDX_W-1:0];
      right_idx     = right_ext[IDX_W-1:0];
      // right child beats left only when strictly larger
      right_wins    = (rd_data_ff > left_val_ff);
      best_val      = right_wins ? rd_data_ff : left_val_ff;
      best_idx      = right_wins ? right_idx : left_idx;
      best_left_ext = {1'b0, best_idx, 1'b1};
   end

   // status back to the controller
   always_comb begin
      stat.op_pop       = (op_ff == OP_POP);
      stat.count_full   = (count_ff == CNT_W'(CAPACITY));
      stat.count_zero   = (count_ff == '0);
      stat.parent_zero  = (parent_idx == '0);
      stat.key_gt_rd    = (key_ff > rd_data_ff);
      stat.rd_gt_key    = (rd_data_ff > key_ff);
      stat.left_in      = (left_ext < count_ext);
      stat.right_in     = (right_ext < count_ext);
      stat.best_gt_key  = (best_val > key_ff);
      stat.best_left_in = (best_left_ext < count_ext);
      stat.out_busy     = rsp_valid_ff && rsp_stall;
   end

   // read address select
   always_comb begin
      case (cmd.rd_addr)
         RA_ROOT:      rd_addr = '0;
         RA_LAST:      rd_addr = IDX_W'(count_ff);
         RA_PARENT:    rd_addr = parent_idx;
         RA_GRAND:     rd_addr = grand_idx;
         RA_LEFT:      rd_addr = left_idx;
         RA_RIGHT:     rd_addr = right_idx;
         RA_BEST_LEFT: rd_addr = best_left_ext[IDX_W-1:0];
         default:      rd_addr = '0;
      endcase
   end

   // write data select
   always_comb begin
      case (cmd.wr_data)
         WD_KEY:  wr_data = key_ff;
         WD_RD:   wr_data = rd_data_ff;
         WD_BEST: wr_data = best_val;
         default: wr_data = key_ff;
      endcase
   end

   // heap store, one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         heap_mem[hole_ff] <= wr_data;
      end
      if (cmd.rd_en) begin
         rd_data_ff <= heap_mem[rd_addr];
      end
   end

   // hole and count next values
   always_comb begin
      case (cmd.hole_op)
         HO_COUNT:  hole_in = IDX_W'(count_ff);
         HO_ROOT:   hole_in = '0;
         HO_PARENT: hole_in = parent_idx;
         HO_LEFT:   hole_in = left_idx;
         HO_BEST:   hole_in = best_idx;
         default:   hole_in = hole_ff;
      endcase
      case (cmd.cnt_op)
         CO_INC:  count_in = count_ff + CNT_W'(1);
         CO_DEC:  count_in = count_ff - CNT_W'(1);
         default: count_in = count_ff;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         if (cmd.respond) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // working payload registers
   always_ff @(posedge clock) begin
      hole_ff <= hole_in;
      if (cmd.load_req) begin
         op_ff  <= opcode_type'(req_opcode);
         key_ff <= KEY_WIDTH'($unsigned(req_value));
      end else if (cmd.load_key_rd) begin
         key_ff <= rd_data_ff;
      end
      if (cmd.load_left) begin
         left_val_ff <= rd_data_ff;
      end
      if (cmd.clr_popped) begin
         popped_ff <= '0;
      end else if (cmd.load_popped) begin
         popped_ff <= rd_data_ff;
      end
      if (cmd.set_status) begin
         res_status_ff <= cmd.status_code;
      end
   end

   // result register, holds while stalled
   always_ff @(posedge clock) begin
      if (cmd.respond) begin
         rsp_popped_ff <= VALUE_W'(popped_ff);
         rsp_status_ff <= res_status_ff;
         rsp_total_ff  <= TOTAL_W'(count_ff);
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_popped_value = rsp_popped_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_entry_total  = rsp_total_ff;

endmodule

`default_nettype wire

### hdl/bmhq_checker.sv
// ----------------------------------------------------------------------------
// bmhq_checker
// Port-level checks for the heap queue, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "binary_max_heap_queue_defines.svh"

module bmhq_checker #(
   parameter int CAPACITY = bmhq_pkg::DEF_CAPACITY
) (
   input wire logic                                 clock,
   input wire logic                                 reset,
   input wire logic                                 req_valid,
   input wire logic                                 req_stall,
   input wire logic                                 rsp_valid,
   input wire logic                                 rsp_stall,
   input wire logic signed [bmhq_pkg::VALUE_W-1:0]  rsp_popped_value,
   input wire logic [bmhq_pkg::STATUS_W-1:0]        rsp_status,
   input wire logic [bmhq_pkg::TOTAL_W-1:0]         rsp_entry_total
);
   import bmhq_pkg::*;

   logic req_beat;
   logic status_ok;

   assign req_beat  = req_valid && !req_stall;
   assign status_ok = (rsp_status == ST_DONE) || (rsp_status == ST_EMPTY)
                      || (rsp_status == ST_FULL);

   // one operation in flight: an accepted beat closes the request side
   `BMHQ_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_beat, req_stall,
      "accepted beat did not raise req_stall")

   // only defined status codes come out
   `BMHQ_ASSERT_NOW(a_status_code, clock, reset, rsp_valid, status_ok,
      "undefined status code")

   // pop on empty leaves nothing behind
   `BMHQ_ASSERT_NOW(a_empty_result, clock, reset,
      rsp_valid && (rsp_status == ST_EMPTY),
      (rsp_entry_total == '0) && (rsp_popped_value == '0),
      "empty pop with entries or value")

   // rejected insert only when the store is full
   `BMHQ_ASSERT_NOW(a_full_result, clock, reset,
      rsp_valid && (rsp_status == ST_FULL),
      (rsp_entry_total == TOTAL_W'(CAPACITY)) && (rsp_popped_value == '0),
      "full status below capacity")

   // stalled result beat holds
   `BMHQ_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall,
      rsp_valid && $stable(rsp_popped_value) && $stable(rsp_status)
      && $stable(rsp_entry_total),
      "stalled result beat changed")

endmodule

bind binary_max_heap_queue bmhq_checker #(
   .CAPACITY (CAPACITY)
) u_bmhq_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_stall        (req_stall),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_popped_value (rsp_popped_value),
   .rsp_status       (rsp_status),
   .rsp_entry_total  (rsp_entry_total)
);

`default_nettype wire

### tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking heap queue bench: drives directed, then random bursts of
// insert and pop beats; mirrors the heap in a scoreboard, checks every result
// beat field by field while the response side stalls on its own pattern.
// ----------------------------------------------------------------------------

module tb;
   import bmhq_pkg::*;

   localparam int HEAP_DEPTH = DEF_CAPACITY;

   typedef struct packed {
      logic signed [VALUE_W-1:0] popped;
      status_type                status;
      logic [TOTAL_W-1:0]        total;
   } heap_reply_type;

   // mirror of the heap and the replies it still owes
   class heap_mirror;
      logic signed [VALUE_W-1:0] keys [HEAP_DEPTH];
      int unsigned               held;
      heap_reply_type            awaited_replies [$];
      int unsigned               mismatches;

      function void report(string what);
         mismatches++;
         if (mismatches <= 10) $display("mismatch at %0t: %s", $realtime, what);
      endfunction

      // apply one accepted beat and queue the reply it owes
      function void take_request(opcode_type op, logic signed [VALUE_W-1:0] val);
         heap_reply_type            r;
         int unsigned               slot;
         int unsigned               up;
         int unsigned               lc;
         int unsigned               rc;
         int unsigned               pick;
         logic signed [VALUE_W-1:0] t;
         r.popped = '0;
         r.status = ST_DONE;
         if (op == OP_INSERT) begin
            if (held >= HEAP_DEPTH) begin
               r.status = ST_FULL;
            end else begin
               // append and climb while strictly larger than the parent
               slot = held;
               keys[slot] = val;
               held++;
               while (slot != 0) begin
                  up = (slot - 1) / 2;
                  if (keys[slot] > keys[up]) begin
                     t = keys[slot];
                     keys[slot] = keys[up];
                     keys[up] = t;
                     slot = up;
                  end else begin
                     break;
                  end
               end
            end
         end else if (held == 0) begin
            r.status = ST_EMPTY;
         end else begin
            // take the root, move the last entry up and sink it
            r.popped = keys[0];
            held--;
            keys[0] = keys[held];
            slot = 0;
            while (1) begin
               lc = slot * 2 + 1;
               rc = lc + 1;
               if (lc >= held) break;
               pick = lc;
               if (rc < held && keys[rc] > keys[lc]) pick = rc;
               if (keys[pick] > keys[slot]) begin
                  t = keys[slot];
                  keys[slot] = keys[pick];
                  keys[pick] = t;
                  slot = pick;
               end else begin
                  break;
               end
            end
         end
         r.total = held[TOTAL_W-1:0];
         awaited_replies.push_back(r);
      endfunction

      // compare one result beat with the oldest owed reply
      function void check_reply(logic signed [VALUE_W-1:0] pv, logic [STATUS_W-1:0] st,
                                logic [TOTAL_W-1:0] tot);
         heap_reply_type r;
         if (awaited_replies.size() == 0) begin
            report($sformatf("unexpected beat popped %0d status %0d total %0d",
                             pv, st, tot));
            return;
         end
         r = awaited_replies.pop_front();
         if (pv !== r.popped)
            report($sformatf("popped_value exp %0d got %0d", r.popped, pv));
         if (st !== r.status)
            report($sformatf("status exp %0d got %0d", r.status, st));
         if (tot !== r.total)
            report($sformatf("entry_total exp %0d got %0d", r.total, tot));
      endfunction
   endclass

   logic                      clock;
   logic                      reset;
   logic                      req_valid;
   logic                      req_stall;
   logic                      req_opcode;
   logic signed [VALUE_W-1:0] req_value;
   logic                      rsp_valid;
   logic                      rsp_stall;
   logic signed [VALUE_W-1:0] rsp_popped_value;
   logic [STATUS_W-1:0]       rsp_status;
   logic [TOTAL_W-1:0]        rsp_entry_total;

   heap_mirror  mirror = new();
   int unsigned burst_left;

   binary_max_heap_queue dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_opcode       (req_opcode),
      .req_value        (req_value),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_popped_value (rsp_popped_value),
      .rsp_status       (rsp_status),
      .rsp_entry_total  (rsp_entry_total)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // offer one beat and hold it until accepted
   task automatic offer(opcode_type op, logic signed [VALUE_W-1:0] val);
      req_valid  <= 1'b1;
      req_opcode <= op;
      req_value  <= val;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      mirror.take_request(op, val);
   endtask

   // random beats in bursts; pop_pct sets the share of pops
   task automatic run_phase(int unsigned beats, int unsigned pop_pct);
      opcode_type                op;
      logic signed [VALUE_W-1:0] val;
      for (int unsigned i = 0; i < beats; i++) begin
         if (burst_left == 0) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clock);
            burst_left = $urandom_range(1, 40);
         end
         burst_left--;
         op = ($urandom_range(0, 99) < pop_pct) ? OP_POP : OP_INSERT;
         // full range, a narrow band for ties, or the extremes
         case ($urandom_range(0, 2))
            0: val = $urandom;
            1: val = $signed($urandom_range(0, 8)) - 4;
            default: begin
               case ($urandom_range(0, 3))
                  0: val = 32'sh7fffffff;
                  1: val = 32'sh80000000;
                  2: val = -1;
                  default: val = 0;
               endcase
            end
         endcase
         offer(op, val);
      end
   endtask

   // result side: check every beat, stall in random segments, one long hold
   initial begin
      int unsigned seg_left;
      int unsigned mode;
      int unsigned hold_left;
      int unsigned seen;
      bit          held_once;
      seg_left  = 0;
      mode      = 0;
      hold_left = 0;
      seen      = 0;
      held_once = 1'b0;
      rsp_stall = 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_valid === 1'b1 && rsp_stall == 1'b0) begin
            mirror.check_reply(rsp_popped_value, rsp_status, rsp_entry_total);
            seen++;
         end
         if (!held_once && seen == 150) begin
            held_once = 1'b1;
            hold_left = 400;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            if (seg_left == 0) begin
               mode     = $urandom_range(0, 2);
               seg_left = $urandom_range(20, 200);
            end
            seg_left--;
            case (mode)
               0: rsp_stall <= 1'b0;
               1: rsp_stall <= ($urandom_range(0, 99) < 30);
               default: rsp_stall <= ($urandom_range(0, 99) < 70);
            endcase
         end
      end
   end

   // stimulus and verdict
   initial begin
      int unsigned waited;
      reset      = 1'b1;
      req_valid  = 1'b0;
      req_opcode = 1'b0;
      req_value  = '0;
      burst_left = 0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // pop on empty, extremes, ties, drain back to empty
      offer(OP_POP, 32'sh12345678);
      offer(OP_INSERT, 0);
      offer(OP_INSERT, 32'sh7fffffff);
      offer(OP_INSERT, 32'sh80000000);
      offer(OP_INSERT, -1);
      offer(OP_INSERT, 1);
      offer(OP_INSERT, 5);
      offer(OP_INSERT, 5);
      offer(OP_INSERT, 5);
      offer(OP_INSERT, 32'sh7fffffff);
      for (int i = 0; i < 9; i++) offer(OP_POP, -1);
      offer(OP_POP, 0);
      offer(OP_INSERT, 32'shaaaaaaaa);
      offer(OP_INSERT, 32'sh55555555);
      offer(OP_POP, 32'sh55555555);
      offer(OP_POP, 32'shaaaaaaaa);

      // mixed traffic near empty, then fill past capacity, then a pop-heavy phase
      run_phase(250, 50);
      run_phase(1150, 3);
      run_phase(350, 80);
      req_valid <= 1'b0;

      waited = 0;
      while (mirror.awaited_replies.size() > 0 && waited < 20000) begin
         @(posedge clock);
         waited++;
      end
      repeat (40) @(posedge clock);
      if (mirror.awaited_replies.size() > 0)
         mirror.report($sformatf("%0d result beats never arrived",
                                 mirror.awaited_replies.size()));
      if (mirror.mismatches == 0) begin
         $display("tb passed");
      end else begin
         $display("tb failed");
      end
      $finish;
   end

   // hard limit on run time
   initial begin
      #4000000;
      $display("tb failed");
      $finish;
   end

endmodule
